// File: rtl/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection pipeline.
// No dependencies; imported by rti_geom and the top level (rti_div needs no package).
`default_nettype none

package rti_pkg;

   // control that travels beside the payload from the last geometry stage on
   typedef struct packed {
      logic valid;
      logic hit;
   } ctl_type;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z    = 3'd5;

   localparam int DIST_W = 24;

endpackage

`default_nettype wire

// File: rtl/rti_div.sv
// Pipelined restoring divider: one quotient bit per stage, plus a saturation
// flag for quotients that do not fit. Stand-alone, no package needed.
`default_nettype none

module rti_div #(
   parameter int NUM_W = 68,
   parameter int DEN_W = 53,
   parameter int QUO_W = 24
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             sat
);

   localparam int R_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic [R_W-1:0]   rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic             sat_ff [QUO_W+1];

   // saturate when the quotient would need more than QUO_W bits
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= R_W'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= R_W'(num) >= (R_W'(den) << QUO_W);
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
      localparam int B = QUO_W - j;
      logic [R_W-1:0] sh;
      logic           ge;

      assign sh = R_W'(den_ff[j-1]) << B;
      assign ge = rem_ff[j-1] >= sh;

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[j]   <= q_ff[j-1] | (ge ? (QUO_W'(1) << B) : QUO_W'(0));
            sat_ff[j] <= sat_ff[j-1];
         end
      end

      if (j < QUO_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j] <= ge ? rem_ff[j-1] - sh : rem_ff[j-1];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quo = q_ff[QUO_W];
   assign sat = sat_ff[QUO_W];

endmodule

`default_nettype wire

// File: rtl/rti_geom.sv
// Geometry front end: edges, cross products, dot products and the hit tests.
// Five register stages; uses rti_pkg for the control struct.
`default_nettype none

module rti_geom import rti_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 8,
   parameter int S_W         = 54
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] corner [9],
   input  logic signed [COORD_WIDTH-1:0] origin [3],
   input  logic signed [COORD_WIDTH-1:0] dir    [3],
   output ctl_type                       out_ctl,
   output logic signed [S_W-1:0]         out_st,
   output logic signed [S_W-1:0]         out_a
);

   localparam int CW  = COORD_WIDTH;
   localparam int E_W = CW + 1;
   localparam int H_W = 2 * CW + 2;
   localparam int Q_W = 2 * CW + 3;
   localparam longint DET_EPS = ((64'sd1 <<< (3 * FRAC_BITS)) + 64'sd99999) / 64'sd100000;
   localparam logic signed [S_W-1:0] EPS_S = S_W'(DET_EPS);
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   logic [3:0] vld_ff;

   // stage 1: edges and origin offset
   logic signed [E_W-1:0] e1_1_in [3], e2_1_in [3], s_1_in [3];
   logic signed [E_W-1:0] e1_1_ff [3], e2_1_ff [3], s_1_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e1_1_in[k] = {corner[3+k][CW-1], corner[3+k]} - {corner[k][CW-1], corner[k]};
         e2_1_in[k] = {corner[6+k][CW-1], corner[6+k]} - {corner[k][CW-1], corner[k]};
         s_1_in[k]  = {origin[k][CW-1], origin[k]} - {corner[k][CW-1], corner[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_1_ff <= e1_1_in;
         e2_1_ff <= e2_1_in;
         s_1_ff  <= s_1_in;
      end
   end

   // stage 2: h = dir x e2, q = s x e1
   logic signed [H_W-1:0] h_2_in [3], h_2_ff [3];
   logic signed [Q_W-1:0] q_2_in [3], q_2_ff [3];
   logic signed [E_W-1:0] e1_2_ff [3], e2_2_ff [3], s_2_ff [3];

   always_comb begin
      logic signed [H_W-1:0] ph_a [3];
      logic signed [H_W-1:0] ph_b [3];
      logic signed [Q_W-1:0] pq_a [3];
      logic signed [Q_W-1:0] pq_b [3];
      for (int k = 0; k < 3; k++) begin
         ph_a[k]   = dir[NXT[k]] * e2_1_ff[PRV[k]];
         ph_b[k]   = dir[PRV[k]] * e2_1_ff[NXT[k]];
         pq_a[k]   = s_1_ff[NXT[k]] * e1_1_ff[PRV[k]];
         pq_b[k]   = s_1_ff[PRV[k]] * e1_1_ff[NXT[k]];
         h_2_in[k] = ph_a[k] - ph_b[k];
         q_2_in[k] = pq_a[k] - pq_b[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_2_ff  <= h_2_in;
         q_2_ff  <= q_2_in;
         e1_2_ff <= e1_1_ff;
         e2_2_ff <= e2_1_ff;
         s_2_ff  <= s_1_ff;
      end
   end

   // stage 3: the twelve dot-product terms
   logic signed [S_W-1:0] pa_in [3], pu_in [3], pv_in [3], pt_in [3];
   logic signed [S_W-1:0] pa_ff [3], pu_ff [3], pv_ff [3], pt_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa_in[k] = e1_2_ff[k] * h_2_ff[k];
         pu_in[k] = s_2_ff[k] * h_2_ff[k];
         pv_in[k] = dir[k] * q_2_ff[k];
         pt_in[k] = e2_2_ff[k] * q_2_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff <= pa_in;
         pu_ff <= pu_in;
         pv_ff <= pv_in;
         pt_ff <= pt_in;
      end
   end

   // stage 4: sums
   logic signed [S_W-1:0] a_4_ff, su_4_ff, sv_4_ff, st_4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_4_ff  <= pa_ff[0] + pa_ff[1] + pa_ff[2];
         su_4_ff <= pu_ff[0] + pu_ff[1] + pu_ff[2];
         sv_4_ff <= pv_ff[0] + pv_ff[1] + pv_ff[2];
         st_4_ff <= pt_ff[0] + pt_ff[1] + pt_ff[2];
      end
   end

   // stage 5: make the determinant positive, then run the tests
   logic signed [S_W-1:0] an, sun, svn, stn;
   logic signed [S_W:0]   sum_uv;
   logic signed [S_W+6:0] st100, an_w;
   logic                  hit_in;
   ctl_type               ctl_ff;
   logic signed [S_W-1:0] st_ff, a_ff;

   always_comb begin
      an     = a_4_ff[S_W-1] ? -a_4_ff  : a_4_ff;
      sun    = a_4_ff[S_W-1] ? -su_4_ff : su_4_ff;
      svn    = a_4_ff[S_W-1] ? -sv_4_ff : sv_4_ff;
      stn    = a_4_ff[S_W-1] ? -st_4_ff : st_4_ff;
      sum_uv = sun + svn;
      st100  = stn * 8'sd100;
      an_w   = an;
      hit_in = vld_ff[3] && (an >= EPS_S) && !(sun < 0) && !(sun > an)
               && !(svn < 0) && !(sum_uv > an) && (st100 > an_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ctl_ff <= '0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[2:0], in_valid};
         ctl_ff.valid <= vld_ff[3];
         ctl_ff.hit   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= stn;
         a_ff  <= an;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_st  = st_ff;
   assign out_a   = a_ff;

endmodule

`default_nettype wire

// File: rtl/ray_triangle_intersect_top.sv
// Ray/triangle intersection, streaming one triangle per request.
// Path from request to result: five geometry stages, two scaling
// multiply stages, a 25-stage bit-per-stage divider and the output register.
// Throughput one request per cycle; a stall at the result side holds every stage.
// Reset clears the pipeline valid bits; the ray resets to origin 0, direction +x.
`default_nettype none

module ray_triangle_intersect_top import rti_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 8,
   localparam int IN_TW      = ((9 * COORD_WIDTH + 7) / 8) * 8,
   localparam int OUT_TW     = ((3 * COORD_WIDTH + 24 + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // corner0_x, corner0_y, corner0_z, corner1_x .. corner2_z, zero pad
   input  logic [IN_TW-1:0]       req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // point_x, point_y, point_z, distance, zero pad
   output logic [OUT_TW-1:0]      rsp_tdata,
   // hit
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0] csr_data
);

   localparam int CW      = COORD_WIDTH;
   localparam int S_W     = 3 * CW + 6;
   localparam int U_W     = S_W - 1;
   localparam int LO_W    = U_W / 2;
   localparam int HI_W    = U_W - LO_W;
   localparam int DD_W    = 2 * CW;
   localparam int NP_W    = U_W + CW;
   localparam int ND_W    = U_W + DD_W;
   localparam int DDEN_W  = U_W + FRAC_BITS;
   localparam int QUO_W   = (CW + 2 > DIST_W) ? CW + 2 : DIST_W;
   localparam int DIV_LAT = QUO_W + 1;
   localparam logic [QUO_W-1:0] CAP  = QUO_W'(1) << (CW + 1);
   localparam logic [QUO_W-1:0] DMAX = QUO_W'((64'd1 << DIST_W) - 64'd1);
   localparam logic signed [CW+2:0] MAX_E = (CW+3)'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [CW+2:0] MIN_E = (CW+3)'(-(64'sd1 <<< (CW - 1)));

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // ray registers
   logic signed [CW-1:0] org_ff [3];
   logic signed [CW-1:0] dir_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff <= '{default: '0};
         dir_ff <= '{CW'(1) << FRAC_BITS, CW'(0), CW'(0)};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ORIGIN_X: org_ff[0] <= csr_data;
            REG_ORIGIN_Y: org_ff[1] <= csr_data;
            REG_ORIGIN_Z: org_ff[2] <= csr_data;
            REG_DIR_X:    dir_ff[0] <= csr_data;
            REG_DIR_Y:    dir_ff[1] <= csr_data;
            REG_DIR_Z:    dir_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // ray-derived constants: |dir| per axis and |dir|^2
   logic [CW-1:0]   dm_in [3], dm_ff [3];
   logic [DD_W-1:0] dd_in, dd_ff;

   always_comb begin
      logic [DD_W-1:0] sq [3];
      for (int k = 0; k < 3; k++) begin
         dm_in[k] = dir_ff[k][CW-1] ? (~dir_ff[k] + 1'b1) : dir_ff[k];
         sq[k]    = dm_in[k] * dm_in[k];
      end
      dd_in = sq[0] + sq[1] + sq[2];
   end

   always_ff @(posedge clock) begin
      dm_ff <= dm_in;
      dd_ff <= dd_in;
   end

   // geometry front end
   logic signed [CW-1:0] corner [9];
   ctl_type              geom_ctl;
   logic signed [S_W-1:0] geom_st, geom_a;

   always_comb begin
      for (int j = 0; j < 9; j++) begin
         corner[j] = req_tdata[j*CW +: CW];
      end
   end

   rti_geom #(
      .COORD_WIDTH (CW),
      .FRAC_BITS   (FRAC_BITS),
      .S_W         (S_W)
   ) u_geom (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .corner   (corner),
      .origin   (org_ff),
      .dir      (dir_ff),
      .out_ctl  (geom_ctl),
      .out_st   (geom_st),
      .out_a    (geom_a)
   );

   // stage 6: partial products of t-numerator with |dir| and |dir|^2
   logic [U_W-1:0]       st_u;
   logic [LO_W+CW-1:0]   pl_in [3], pl_ff [3];
   logic [HI_W+CW-1:0]   ph_in [3], ph_ff [3];
   logic [LO_W+DD_W-1:0] dl_in, dl_ff;
   logic [HI_W+DD_W-1:0] dh_in, dh_ff;
   logic [U_W-1:0]       a6_ff;
   ctl_type              ctl6_ff;

   always_comb begin
      st_u = geom_st[U_W-1:0];
      for (int k = 0; k < 3; k++) begin
         pl_in[k] = st_u[LO_W-1:0] * dm_ff[k];
         ph_in[k] = st_u[U_W-1:LO_W] * dm_ff[k];
      end
      dl_in = st_u[LO_W-1:0] * dd_ff;
      dh_in = st_u[U_W-1:LO_W] * dd_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff <= pl_in;
         ph_ff <= ph_in;
         dl_ff <= dl_in;
         dh_ff <= dh_in;
         a6_ff <= geom_a[U_W-1:0];
      end
   end

   // stage 7: assemble the dividends
   logic [NP_W-1:0] np_ff [3];
   logic [ND_W-1:0] nd_ff;
   logic [U_W-1:0]  a7_ff;
   ctl_type         ctl7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            np_ff[k] <= (NP_W'(ph_ff[k]) << LO_W) + NP_W'(pl_ff[k]);
         end
         nd_ff <= (ND_W'(dh_ff) << LO_W) + ND_W'(dl_ff);
         a7_ff <= a6_ff;
      end
   end

   // dividers
   logic [QUO_W-1:0] q_pt [3];
   logic             sat_pt [3];
   logic [QUO_W-1:0] q_ds;
   logic             sat_ds;

   for (genvar k = 0; k < 3; k++) begin : g_pdiv
      rti_div #(
         .NUM_W (NP_W),
         .DEN_W (U_W),
         .QUO_W (QUO_W)
      ) u_div (
         .clock (clock),
         .adv   (adv),
         .num   (np_ff[k]),
         .den   (a7_ff),
         .quo   (q_pt[k]),
         .sat   (sat_pt[k])
      );
   end

   rti_div #(
      .NUM_W (ND_W),
      .DEN_W (DDEN_W),
      .QUO_W (QUO_W)
   ) u_ddiv (
      .clock (clock),
      .adv   (adv),
      .num   (nd_ff),
      .den   (DDEN_W'(a7_ff) << FRAC_BITS),
      .quo   (q_ds),
      .sat   (sat_ds)
   );

   // control runs beside the divider
   ctl_type ctl_d_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl6_ff  <= '0;
         ctl7_ff  <= '0;
         ctl_d_ff <= '{default: '0};
      end else if (adv) begin
         ctl6_ff     <= geom_ctl;
         ctl7_ff     <= ctl6_ff;
         ctl_d_ff[0] <= ctl7_ff;
         for (int j = 1; j < DIV_LAT; j++) begin
            ctl_d_ff[j] <= ctl_d_ff[j-1];
         end
      end
   end

   // final: offset along the ray, clamp, drop payload on a miss
   logic [CW-1:0]     pt_in [3];
   logic [DIST_W-1:0] ds_in;
   ctl_type           ctl_last;

   assign ctl_last = ctl_d_ff[DIV_LAT-1];

   always_comb begin
      logic [CW+1:0]          off;
      logic signed [CW+2:0]   ext_o, ext_off, val;
      for (int k = 0; k < 3; k++) begin
         off     = (sat_pt[k] || q_pt[k] > CAP) ? CAP[CW+1:0] : q_pt[k][CW+1:0];
         ext_o   = (CW+3)'(org_ff[k]);
         ext_off = {1'b0, off};
         val     = dir_ff[k][CW-1] ? ext_o - ext_off : ext_o + ext_off;
         if (!ctl_last.hit) begin
            pt_in[k] = '0;
         end else if (val > MAX_E) begin
            pt_in[k] = MAX_E[CW-1:0];
         end else if (val < MIN_E) begin
            pt_in[k] = MIN_E[CW-1:0];
         end else begin
            pt_in[k] = val[CW-1:0];
         end
      end
      if (!ctl_last.hit) begin
         ds_in = '0;
      end else if (sat_ds || q_ds > DMAX) begin
         ds_in = DMAX[DIST_W-1:0];
      end else begin
         ds_in = q_ds[DIST_W-1:0];
      end
   end

   // output register
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [CW-1:0]     rsp_pt_ff [3];
   logic [DIST_W-1:0] rsp_ds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= ctl_last.hit;
         rsp_pt_ff  <= pt_in;
         rsp_ds_ff  <= ds_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = OUT_TW'({rsp_ds_ff, rsp_pt_ff[2], rsp_pt_ff[1], rsp_pt_ff[0]});

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss result carries a non-zero payload");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_geom_hit : assert property (@(posedge clock) disable iff (reset)
      geom_ctl.hit |-> geom_ctl.valid)
      else $error("hit flagged on an empty geometry slot");

endmodule

`default_nettype wire
